// File: hdl/assert_macros.svh
// Assertion macros used by the top RTL file of the bit pair serial counter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BPSC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BPSC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: hdl/bpsc_pkg.sv
// Types, constants and helper functions of the bit pair serial counter.
package bpsc_pkg;

  localparam int unsigned CntW     = 28;
  localparam int unsigned ByteBits = 8;
  localparam int unsigned PairIdxW = 2;

  typedef logic [CntW-1:0] cnt_t;

  localparam cnt_t CntMax = {CntW{1'b1}};

  // Indexes into the pair counters: earlier bit times two plus later bit.
  localparam logic [PairIdxW-1:0] Pair00 = 2'd0;
  localparam logic [PairIdxW-1:0] Pair01 = 2'd1;
  localparam logic [PairIdxW-1:0] Pair10 = 2'd2;
  localparam logic [PairIdxW-1:0] Pair11 = 2'd3;

  // Per-byte statistics computed before the input register.
  typedef struct packed {
    logic [3:0]      ones;   // one bits in the byte, 0 to 8
    logic [3:0][2:0] intra;  // pairs inside the byte, 0 to 7 each
    logic            msb;    // earliest bit
    logic            lsb;    // latest bit
  } byte_stats_t;

  // Running totals after the current byte has been counted.
  typedef struct packed {
    cnt_t        total;
    cnt_t        ones;
    cnt_t [3:0]  pairs;
  } counts_t;

  // Saturating add of a small increment to a counter.
  function automatic cnt_t sat_add(cnt_t a, logic [3:0] b);
    logic [CntW:0] s;
    s = {1'b0, a} + {{(CntW - 3){1'b0}}, b};
    return s[CntW] ? CntMax : s[CntW-1:0];
  endfunction

endpackage

// File: hdl/bpsc_byte_stats.sv
// Per-byte bit count and count of the seven adjacent pairs inside the byte.
module bpsc_byte_stats import bpsc_pkg::*; (
  input  logic [7:0]  data_i,
  output byte_stats_t stats_o
);

  always_comb begin
    stats_o = '0;
    for (int k = 0; k < ByteBits; k++) begin
      stats_o.ones = stats_o.ones + {3'b000, data_i[k]};
    end
    // Bit k+1 comes before bit k, so data_i[k+1:k] is the pair index.
    for (int k = 0; k < ByteBits - 1; k++) begin
      stats_o.intra[data_i[k+:2]] = stats_o.intra[data_i[k+:2]] + 3'd1;
    end
    stats_o.msb = data_i[ByteBits-1];
    stats_o.lsb = data_i[0];
  end

endmodule

// File: hdl/bpsc_accum.sv
// Slice counters with boundary and wrap-around pair handling.
module bpsc_accum import bpsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        last_i,
  input  byte_stats_t stats_i,
  output counts_t     counts_o
);

  cnt_t            bit_total_q, bit_total_d;
  cnt_t            ones_total_q, ones_total_d;
  cnt_t [3:0]      pairs_q, pairs_d;
  logic            prev_lsb_q, prev_lsb_d;
  logic            first_bit_q, first_bit_d;
  logic            at_start_q, at_start_d;
  logic [3:0][3:0] add;
  logic            first_eff;

  always_comb begin
    add = '0;
    for (int k = 0; k < 4; k++) begin
      add[k] = {1'b0, stats_i.intra[k]};
    end
    first_eff = at_start_q ? stats_i.msb : first_bit_q;
    // Pair across the boundary from the previous byte.
    if (!at_start_q) begin
      add[{prev_lsb_q, stats_i.msb}] = add[{prev_lsb_q, stats_i.msb}] + 4'd1;
    end
    // Wrap-around pair from the final bit back to the first bit.
    if (last_i) begin
      add[{stats_i.lsb, first_eff}] = add[{stats_i.lsb, first_eff}] + 4'd1;
    end

    counts_o.total = sat_add(bit_total_q, 4'(ByteBits));
    counts_o.ones  = sat_add(ones_total_q, stats_i.ones);
    for (int k = 0; k < 4; k++) begin
      counts_o.pairs[k] = sat_add(pairs_q[k], add[k]);
    end
  end

  always_comb begin
    bit_total_d  = bit_total_q;
    ones_total_d = ones_total_q;
    pairs_d      = pairs_q;
    prev_lsb_d   = prev_lsb_q;
    first_bit_d  = first_bit_q;
    at_start_d   = at_start_q;
    if (step_i) begin
      prev_lsb_d  = stats_i.lsb;
      first_bit_d = first_eff;
      if (last_i) begin
        bit_total_d  = '0;
        ones_total_d = '0;
        pairs_d      = '0;
        at_start_d   = 1'b1;
      end else begin
        bit_total_d  = counts_o.total;
        ones_total_d = counts_o.ones;
        pairs_d      = counts_o.pairs;
        at_start_d   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_total_q  <= '0;
      ones_total_q <= '0;
      pairs_q      <= '0;
      prev_lsb_q   <= 1'b0;
      first_bit_q  <= 1'b0;
      at_start_q   <= 1'b1;
    end else begin
      bit_total_q  <= bit_total_d;
      ones_total_q <= ones_total_d;
      pairs_q      <= pairs_d;
      prev_lsb_q   <= prev_lsb_d;
      first_bit_q  <= first_bit_d;
      at_start_q   <= at_start_d;
    end
  end

endmodule

// File: hdl/bit_pair_serial_counter.sv
// A slice's result beat is registered in the result register when its final byte leaves the input register.
// Throughput: one byte per cycle unless the input stage is held, set by the counter update in bpsc_accum.
// Only a final byte meeting a result that is still waiting holds the input stage.
// Reset (rst_ni low, asynchronous): counters clear, the next byte opens a new slice,
// and both the input stage and the result register are empty.
`include "assert_macros.svh"

module bit_pair_serial_counter import bpsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_in_slice_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cnt_t       total_bits_o,
  output cnt_t       zero_count_o,
  output cnt_t       one_count_o,
  output cnt_t       pairs_00_o,
  output cnt_t       pairs_01_o,
  output cnt_t       pairs_10_o,
  output cnt_t       pairs_11_o
);

  // The byte statistics (popcount and the seven inner pairs) are formed
  // from the input beat and captured in the input register together with
  // the last flag.
  byte_stats_t in_stats;
  byte_stats_t s1_stats_q;
  logic        s1_last_q;
  logic        s1_valid_q;
  logic        s1_adv;
  logic        in_fire;

  // Result register. The zero count is formed at the output from the held
  // bit and one totals.
  counts_t     counts;
  counts_t     out_q;
  logic        out_valid_q;
  logic        out_load;

  bpsc_byte_stats u_byte_stats (
    .data_i  (data_byte_i),
    .stats_o (in_stats)
  );

  // The registered byte moves into the counters unless it closes a slice
  // and the result register still holds a beat that is not being taken.
  assign s1_adv     = s1_valid_q && (!s1_last_q || !out_valid_q || out_ready_i);
  assign out_load   = s1_adv && s1_last_q;
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_stats_q <= in_stats;
      s1_last_q  <= last_in_slice_i;
    end
  end

  bpsc_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .last_i   (s1_last_q),
    .stats_i  (s1_stats_q),
    .counts_o (counts)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= counts;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign total_bits_o = out_q.total;
  // Ones never exceed the bit total, so this difference is never negative.
  assign zero_count_o = out_q.total - out_q.ones;
  assign one_count_o  = out_q.ones;
  assign pairs_00_o   = out_q.pairs[Pair00];
  assign pairs_01_o   = out_q.pairs[Pair01];
  assign pairs_10_o   = out_q.pairs[Pair10];
  assign pairs_11_o   = out_q.pairs[Pair11];

  // A result beat that is taken without a new one behind it leaves the register empty.
  `BPSC_ASSERT_NEXT(a_out_drain, clk_i, rst_ni, out_valid_q && out_ready_i && !out_load, !out_valid_q)
  // A held byte that does not advance is not overwritten.
  `BPSC_ASSERT_NEXT(a_s1_hold, clk_i, rst_ni, s1_valid_q && !s1_adv, s1_valid_q && $stable(s1_stats_q))
  // The one count of a slice never exceeds its bit count.
  `BPSC_ASSERT_IMPLY(a_ones_le_total, clk_i, rst_ni, out_valid_q, out_q.ones <= out_q.total)
  // On a circular slice, rising and falling edges balance until saturation.
  `BPSC_ASSERT_IMPLY(a_edges_balance, clk_i, rst_ni, out_valid_q && out_q.total != CntMax, out_q.pairs[Pair01] == out_q.pairs[Pair10])

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench of the bit pair serial counter: directed and random slices.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpsc_pkg::*;

  // One byte waiting to be offered on the input channel.
  typedef struct {
    logic [7:0] data;
    logic       fin;
  } byte_beat_t;

  // The seven counts that one slice produces.
  typedef struct {
    cnt_t total;
    cnt_t zeros;
    cnt_t ones;
    cnt_t p00;
    cnt_t p01;
    cnt_t p10;
    cnt_t p11;
  } slice_counts_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_in_slice_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  cnt_t       total_bits_o;
  cnt_t       zero_count_o;
  cnt_t       one_count_o;
  cnt_t       pairs_00_o;
  cnt_t       pairs_01_o;
  cnt_t       pairs_10_o;
  cnt_t       pairs_11_o;

  bit_pair_serial_counter i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .data_byte_i,
    .last_in_slice_i,
    .out_valid_o,
    .out_ready_i,
    .total_bits_o,
    .zero_count_o,
    .one_count_o,
    .pairs_00_o,
    .pairs_01_o,
    .pairs_10_o,
    .pairs_11_o
  );

  // Bytes still to be offered, and the slice counts still to come back.
  byte_beat_t    byte_q[$];
  slice_counts_t expected_q[$];

  int unsigned bytes_loaded = 0;
  int unsigned bytes_sent = 0;
  int unsigned slices_checked = 0;
  int unsigned mismatches = 0;

  // Chance in percent that the sender idles or the receiver stalls on a cycle.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;

  // High for the cycle after an input beat was taken.
  logic in_beat_q = 1'b0;

  // Running counts of the slice under way, as the block should hold them.
  cnt_t acc_bits = '0;
  cnt_t acc_ones = '0;
  cnt_t acc_pairs[4] = '{default: '0};
  logic prev_lsb = 1'b0;
  logic first_bit = 1'b0;
  logic opening = 1'b1;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Counters stick at the all-ones value instead of wrapping.
  function automatic cnt_t add_sticky(cnt_t a, int unsigned b);
    logic [CntW:0] s;
    s = {1'b0, a} + (CntW + 1)'(b);
    return (s > {1'b0, CntMax}) ? CntMax : s[CntW-1:0];
  endfunction

  // Folds one accepted byte into the running counts. Bits go MSB first, so in
  // the pair b[k+1], b[k] the higher bit is the earlier one. The pair that
  // crosses from the previous byte is only counted once a slice is open, and
  // the final byte adds the wrap-around pair from its LSB back to the first
  // bit of the slice. On a one-byte slice that pair joins the byte to itself.
  task automatic count_byte(logic [7:0] b, logic fin);
    int unsigned   tally[4];
    slice_counts_t res;
    tally = '{default: 0};
    for (int k = 0; k < 7; k++) begin
      tally[b[k +: 2]]++;
    end
    if (opening) begin
      first_bit = b[7];
      opening = 1'b0;
    end else begin
      tally[{prev_lsb, b[7]}]++;
    end
    if (fin) begin
      tally[{b[0], first_bit}]++;
    end
    acc_bits = add_sticky(acc_bits, ByteBits);
    acc_ones = add_sticky(acc_ones, $countones(b));
    for (int k = 0; k < 4; k++) begin
      acc_pairs[k] = add_sticky(acc_pairs[k], tally[k]);
    end
    prev_lsb = b[0];
    if (fin) begin
      // Zeros are derived from the totals as held, so they stay exact until
      // the bit counter itself sticks.
      res.total = acc_bits;
      res.zeros = acc_bits - acc_ones;
      res.ones  = acc_ones;
      res.p00   = acc_pairs[Pair00];
      res.p01   = acc_pairs[Pair01];
      res.p10   = acc_pairs[Pair10];
      res.p11   = acc_pairs[Pair11];
      expected_q.push_back(res);
      acc_bits = '0;
      acc_ones = '0;
      acc_pairs = '{default: '0};
      opening = 1'b1;
    end
  endtask

  task automatic check_count(string name, cnt_t want, cnt_t got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Monitor: outputs and handshakes are sampled at the rising edge. A result
  // beat is checked before the input beat of the same edge is counted, so a
  // result can never be matched against a slice that closes in that cycle.
  always @(posedge clk_i) begin : monitor
    slice_counts_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t ns: result beat with no slice outstanding, total_bits %0d",
                   $time, total_bits_o);
          mismatches++;
        end else begin
          want = expected_q.pop_front();
          check_count("total_bits", want.total, total_bits_o);
          check_count("zero_count", want.zeros, zero_count_o);
          check_count("one_count", want.ones, one_count_o);
          check_count("pairs_00", want.p00, pairs_00_o);
          check_count("pairs_01", want.p01, pairs_01_o);
          check_count("pairs_10", want.p10, pairs_10_o);
          check_count("pairs_11", want.p11, pairs_11_o);
          slices_checked++;
        end
      end
      if (in_valid_i && in_ready_o) begin
        count_byte(data_byte_i, last_in_slice_i);
        bytes_sent++;
      end
    end
    in_beat_q <= rst_ni && in_valid_i && in_ready_o;
  end

  // Driver: inputs change at the falling edge. A new byte is offered only when
  // the channel is empty or its byte was just taken; otherwise valid and the
  // payload hold. Each signal gets at most one assignment per edge.
  always @(negedge clk_i) begin : driver
    byte_beat_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_beat_q) begin
      if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = byte_q.pop_front();
        in_valid_i      <= 1'b1;
        data_byte_i     <= nxt.data;
        last_in_slice_i <= nxt.fin;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic queue_byte(logic [7:0] data, logic fin);
    byte_beat_t bb;
    bb.data = data;
    bb.fin  = fin;
    byte_q.push_back(bb);
    bytes_loaded++;
  endtask

  // Random bytes lean on the patterns that make pair counts interesting:
  // solid runs, alternation, a lone one and a lone zero.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return $urandom_range(1) ? 8'hAA : 8'h55;
      3: return 8'h01 << $urandom_range(7);
      4: return ~(8'h01 << $urandom_range(7));
      default: return 8'($urandom());
    endcase
  endfunction

  task automatic queue_slice(int unsigned len);
    for (int unsigned i = 1; i <= len; i++) begin
      queue_byte(pick_byte(), i == len);
    end
  endtask

  // Mostly short slices so many results come back, now and then a long one.
  task automatic queue_random(int unsigned budget);
    int unsigned start;
    start = bytes_loaded;
    while (bytes_loaded - start < budget) begin
      queue_slice(($urandom_range(9) == 0) ? $urandom_range(11, 48) : $urandom_range(1, 10));
    end
  endtask

  // Holds the stimulus back until every byte is in and every slice has answered.
  task automatic wait_drained();
    while (bytes_sent != bytes_loaded || expected_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  initial begin : stimulus
    logic [7:0] singles[6];
    singles = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55};
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct  = 13;
    recv_stall_pct = 60;

    // One-byte slices: the wrap pair closes each byte on itself.
    foreach (singles[i]) begin
      queue_byte(singles[i], 1'b1);
    end
    // Two-byte slices where the boundary pair and the wrap pair differ.
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b1);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b1);
    queue_byte(8'h80, 1'b0);
    queue_byte(8'h01, 1'b1);
    // Longer slice: several non-final beats that return nothing.
    queue_byte(8'h0F, 1'b0);
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h3C, 1'b0);
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'h7E, 1'b1);
    wait_drained();

    queue_random(200);
    wait_drained();

    send_idle_pct  = 60;
    recv_stall_pct = 13;
    queue_random(200);
    wait_drained();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    queue_random(200);
    wait_drained();

    // Idle after the drain to catch stray result beats.
    repeat (8) @(negedge clk_i);

    $display("Run covered %0d bytes and %0d checked slices under three idle and stall mixes.",
             bytes_sent, slices_checked);
    if (mismatches == 0) begin
      $display("** bit_pair_serial_counter: PASSED **");
    end else begin
      $display("%0d mismatches found.", mismatches);
      $display("** bit_pair_serial_counter: FAILED **");
    end
    $finish;
  end

  // Watchdog far beyond the slowest correct run.
  initial begin : watchdog
    #2000000;
    $display("Timeout with %0d of %0d bytes sent and %0d slices outstanding.",
             bytes_sent, bytes_loaded, expected_q.size());
    $display("** bit_pair_serial_counter: FAILED **");
    $finish;
  end

endmodule
